// File: rtl/acesc_pkg.sv
// Shared types and constants for the ANSI-C escape decoder.
`default_nettype none

package acesc_pkg;

    // Parse phases
    localparam logic [2:0] PH_NORMAL    = 3'd0;
    localparam logic [2:0] PH_BACKSLASH = 3'd1;
    localparam logic [2:0] PH_OCTAL     = 3'd2;
    localparam logic [2:0] PH_HEX       = 3'd3;
    localparam logic [2:0] PH_CTRL      = 3'd4;
    localparam logic [2:0] PH_CTRL_BS   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_ECHO   = 2'd0;
    localparam logic [1:0] CFG_DOLLAR = 2'd1;
    localparam logic [1:0] CFG_DROP   = 2'd2;
    localparam logic [1:0] CFG_STOPC  = 2'd3;

    localparam logic [7:0]  CH_PREFIX  = 8'h01;
    localparam logic [7:0]  CH_DEL     = 8'h7F;
    localparam logic [7:0]  CH_ESC     = 8'h1B;
    localparam logic [7:0]  CTRL_MASK  = 8'h1F;
    localparam logic [7:0]  CH_BSLASH  = 8'h5C;
    localparam logic [15:0] TALLY_MAX  = 16'hFFFF;
    localparam int          MAX_BEATS  = 3;

    typedef struct packed {
        logic echo_mode;
        logic dollar_quote_mode;
        logic drop_unknown_backslash;
        logic stop_at_c;
    } acesc_cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  value;
        logic [1:0]  digits;
        logic        brace;
        logic        halted;
        logic [15:0] tally;
    } acesc_state_t;

    // Result beats caused by one input byte
    typedef struct packed {
        logic [1:0]                   n;
        logic [MAX_BEATS-1:0][7:0]    bytes;
        logic                         bare;
        logic                         last;
        logic                         stopped;
        logic [15:0]                  count;
    } acesc_grp_t;

endpackage

`default_nettype wire

// File: rtl/ansi_c_escape_decoder.sv
// Top level of the ANSI-C escape decoder: configuration, parse state and result queue.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_in_byte[7:0], s_in_last
//  m_        out        m_valid / m_ready   m_out_byte[7:0], m_byte_valid, m_out_last,
//                                           m_stopped, m_out_count[15:0]
//  cfg_      in         cfg_we (no wait)    cfg_index[1:0], cfg_wdata[0]
//
// A byte is decoded in the cycle it is accepted; its results leave from the next cycle on.
// One byte per cycle while each byte yields at most one beat and m_ready is high; a byte
// yielding more beats holds s_ready low until the single result group register drains.
// Reset (synchronous, aresetn low) clears configuration, parse state and the result queue.
// A stall on m_ready holds the current beat and backs up into s_ready.
`default_nettype none

module ansi_c_escape_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_in_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_out_last,
    output logic             m_stopped,
    output logic [15:0]      m_out_count,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [0:0]  cfg_wdata
);
    import acesc_pkg::*;

    acesc_cfg_t   cfg_reg, cfg_next;
    acesc_state_t st_reg, st_next;
    acesc_state_t dec_state;
    acesc_grp_t   dec_grp;
    logic         accept;

    // Beat accepted on the input side
    assign accept = s_valid && s_ready;

    // Configuration writes: one bit per register, taken straight away
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_ECHO:   cfg_next.echo_mode              = cfg_wdata[0];
                CFG_DOLLAR: cfg_next.dollar_quote_mode      = cfg_wdata[0];
                CFG_DROP:   cfg_next.drop_unknown_backslash = cfg_wdata[0];
                CFG_STOPC:  cfg_next.stop_at_c              = cfg_wdata[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // Parse state: advance only on an accepted beat
    assign st_next = accept ? dec_state : st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
            st_reg  <= '0;
        end else begin
            cfg_reg <= cfg_next;
            st_reg  <= st_next;
        end
    end

    // Decode the incoming byte against the current parse state
    acesc_decode u_decode (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .st_next (dec_state),
        .grp     (dec_grp)
    );

    // Hold the result group and hand its beats out in order
    acesc_outq u_outq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (accept),
        .grp_in       (dec_grp),
        .in_ready     (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_out_last   (m_out_last),
        .m_stopped    (m_stopped),
        .m_out_count  (m_out_count)
    );

    a_halt_no_text: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.halted |-> (st_reg.phase == PH_NORMAL))
        else $error("halted with an escape pending");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_in_last) |=> (st_reg.tally == 16'd0 && !st_reg.halted))
        else $error("string state not cleared after last byte");

    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && st_reg.halted) |-> (dec_grp.n == 2'd0))
        else $error("result produced after stop");

endmodule

`default_nettype wire

// File: rtl/acesc_decode.sv
// Combinational escape decoder: parse state and one byte in, next state and result group out.
`default_nettype none

module acesc_decode (
    input  wire acesc_pkg::acesc_cfg_t   cfg,
    input  wire acesc_pkg::acesc_state_t st,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    in_last,
    output acesc_pkg::acesc_state_t      st_next,
    output acesc_pkg::acesc_grp_t        grp
);
    import acesc_pkg::*;

    function automatic acesc_grp_t push(acesc_grp_t g, logic [7:0] b);
        if (g.n != 2'd3) begin
            g.bytes[g.n] = b;
            g.n          = g.n + 2'd1;
        end
        return g;
    endfunction

    function automatic acesc_grp_t push_esc(acesc_grp_t g, logic [7:0] b, logic dollar);
        if (dollar && (b == CH_PREFIX || b == CH_DEL)) begin
            g = push(g, CH_PREFIX);
        end
        return push(g, b);
    endfunction

    function automatic acesc_grp_t push_unknown(acesc_grp_t g, logic [7:0] b, acesc_cfg_t c);
        if (!c.drop_unknown_backslash) begin
            g = push(g, CH_BSLASH);
        end
        return push_esc(g, b, c.dollar_quote_mode);
    endfunction

    // Upper-casing only clears bit 5, which the mask clears anyway
    function automatic logic [7:0] to_ctrl(logic [7:0] b);
        return b & CTRL_MASK;
    endfunction

    // Complete whatever escape is pending
    function automatic acesc_grp_t flush(acesc_grp_t g, acesc_state_t s, acesc_cfg_t c);
        case (s.phase)
            PH_BACKSLASH: g = push(g, CH_BSLASH);
            PH_OCTAL:     g = push_esc(g, s.value, c.dollar_quote_mode);
            PH_HEX: begin
                if (!s.brace && s.digits == 2'd2) begin
                    g = push(g, CH_BSLASH);
                    g = push(g, "x");
                end else begin
                    g = push_esc(g, s.value, c.dollar_quote_mode);
                end
            end
            PH_CTRL:      g = push_unknown(g, "c", c);
            PH_CTRL_BS:   g = push_esc(g, to_ctrl(CH_BSLASH), c.dollar_quote_mode);
            default:      g = g;
        endcase
        return g;
    endfunction

    acesc_grp_t   g;
    acesc_state_t ns;
    logic         is_bs;
    logic         is_oct;
    logic         is_hex;
    logic [3:0]   hex_val;
    logic [1:0]   nbytes;
    logic [16:0]  tally_sum;
    logic [15:0]  tally_sat;

    assign is_bs  = (in_byte == CH_BSLASH);
    assign is_oct = in_byte inside {["0":"7"]};

    always_comb begin
        is_hex  = 1'b0;
        hex_val = in_byte[3:0];
        if (in_byte inside {["0":"9"]}) begin
            is_hex = 1'b1;
        end else if (in_byte inside {["a":"f"], ["A":"F"]}) begin
            is_hex  = 1'b1;
            hex_val = in_byte[3:0] + 4'd9;
        end
    end

    always_comb begin
        g         = '0;
        ns        = st;
        nbytes    = 2'd0;
        tally_sum = '0;
        tally_sat = '0;
        if (st.halted) begin
            // drop everything up to the end of the string
            if (in_last) begin
                ns = '0;
            end
        end else begin
            case (st.phase)
                PH_BACKSLASH: begin
                    ns.phase = PH_NORMAL;
                    case (in_byte)
                        "a":      g = push_esc(g, 8'd7, cfg.dollar_quote_mode);
                        "v":      g = push_esc(g, 8'd11, cfg.dollar_quote_mode);
                        "b":      g = push_esc(g, 8'd8, cfg.dollar_quote_mode);
                        "e", "E": g = push_esc(g, CH_ESC, cfg.dollar_quote_mode);
                        "f":      g = push_esc(g, 8'd12, cfg.dollar_quote_mode);
                        "n":      g = push_esc(g, 8'd10, cfg.dollar_quote_mode);
                        "r":      g = push_esc(g, 8'd13, cfg.dollar_quote_mode);
                        "t":      g = push_esc(g, 8'd9, cfg.dollar_quote_mode);
                        "0": begin
                            ns.value  = 8'd0;
                            ns.digits = cfg.echo_mode ? 2'd3 : 2'd2;
                            ns.phase  = PH_OCTAL;
                        end
                        "1", "2", "3", "4", "5", "6", "7": begin
                            if (cfg.echo_mode) begin
                                g = push(g, CH_BSLASH);
                                g = push_esc(g, in_byte, cfg.dollar_quote_mode);
                            end else begin
                                ns.value  = {5'd0, in_byte[2:0]};
                                ns.digits = 2'd2;
                                ns.phase  = PH_OCTAL;
                            end
                        end
                        "x": begin
                            ns.value  = 8'd0;
                            ns.digits = 2'd2;
                            ns.brace  = 1'b0;
                            ns.phase  = PH_HEX;
                        end
                        CH_BSLASH: g = push_esc(g, CH_BSLASH, cfg.dollar_quote_mode);
                        "'", "\"", "?": begin
                            if (cfg.echo_mode) begin
                                g = push(g, CH_BSLASH);
                            end
                            g = push_esc(g, in_byte, cfg.dollar_quote_mode);
                        end
                        "c": begin
                            if (cfg.stop_at_c) begin
                                ns.halted = 1'b1;
                                g.n       = 2'd1;
                                g.bare    = 1'b1;
                                g.last    = 1'b1;
                                g.stopped = 1'b1;
                            end else if (!cfg.echo_mode) begin
                                ns.phase = PH_CTRL;
                            end else begin
                                g = push_unknown(g, in_byte, cfg);
                            end
                        end
                        default: g = push_unknown(g, in_byte, cfg);
                    endcase
                end
                PH_OCTAL: begin
                    if (is_oct) begin
                        ns.value  = {st.value[4:0], in_byte[2:0]};
                        ns.digits = st.digits - 2'd1;
                        if (ns.digits == 2'd0) begin
                            g        = push_esc(g, ns.value, cfg.dollar_quote_mode);
                            ns.phase = PH_NORMAL;
                        end
                    end else begin
                        g         = flush(g, st, cfg);
                        ns.digits = 2'd0;
                        ns.brace  = 1'b0;
                        ns.phase  = is_bs ? PH_BACKSLASH : PH_NORMAL;
                        if (!is_bs) begin
                            g = push(g, in_byte);
                        end
                    end
                end
                PH_HEX: begin
                    if (!st.brace && st.digits == 2'd2 && cfg.dollar_quote_mode &&
                        in_byte == "{") begin
                        ns.brace = 1'b1;
                    end else if (st.brace) begin
                        if (is_hex) begin
                            ns.value = {st.value[3:0], hex_val};
                        end else begin
                            g         = flush(g, st, cfg);
                            ns.digits = 2'd0;
                            ns.brace  = 1'b0;
                            ns.phase  = PH_NORMAL;
                            // a closing brace is swallowed
                            if (in_byte != "}") begin
                                if (is_bs) begin
                                    ns.phase = PH_BACKSLASH;
                                end else begin
                                    g = push(g, in_byte);
                                end
                            end
                        end
                    end else if (is_hex && st.digits != 2'd0) begin
                        ns.value  = {st.value[3:0], hex_val};
                        ns.digits = st.digits - 2'd1;
                        if (ns.digits == 2'd0) begin
                            g        = push_esc(g, ns.value, cfg.dollar_quote_mode);
                            ns.phase = PH_NORMAL;
                        end
                    end else begin
                        g         = flush(g, st, cfg);
                        ns.digits = 2'd0;
                        ns.brace  = 1'b0;
                        ns.phase  = is_bs ? PH_BACKSLASH : PH_NORMAL;
                        if (!is_bs) begin
                            g = push(g, in_byte);
                        end
                    end
                end
                PH_CTRL: begin
                    if (cfg.dollar_quote_mode && is_bs) begin
                        ns.phase = PH_CTRL_BS;
                    end else begin
                        ns.phase = PH_NORMAL;
                        g        = push_esc(g, to_ctrl(in_byte), cfg.dollar_quote_mode);
                    end
                end
                PH_CTRL_BS: begin
                    g        = push_esc(g, to_ctrl(CH_BSLASH), cfg.dollar_quote_mode);
                    ns.phase = is_bs ? PH_NORMAL : PH_NORMAL;
                    if (!is_bs) begin
                        if (in_byte == CH_BSLASH) begin
                            ns.phase = PH_BACKSLASH;
                        end else begin
                            g = push(g, in_byte);
                        end
                    end
                end
                default: begin
                    ns.phase = is_bs ? PH_BACKSLASH : PH_NORMAL;
                    if (!is_bs) begin
                        g = push(g, in_byte);
                    end
                end
            endcase

            if (in_last && !ns.halted) begin
                if (ns.phase != PH_NORMAL) begin
                    g = flush(g, ns, cfg);
                end
                if (g.n == 2'd0) begin
                    g.n    = 2'd1;
                    g.bare = 1'b1;
                end
                g.last = 1'b1;
            end

            // saturating byte tally; at most three bytes per step
            nbytes    = g.bare ? 2'd0 : g.n;
            tally_sum = {1'b0, st.tally} + 17'(nbytes);
            tally_sat = tally_sum[16] ? TALLY_MAX : tally_sum[15:0];
            g.count   = tally_sat;
            ns.tally  = tally_sat;
            if (in_last) begin
                ns = '0;
            end
        end
    end

    assign st_next = ns;
    assign grp     = g;

endmodule

`default_nettype wire

// File: rtl/acesc_outq.sv
// Result group register that hands out up to three beats, one per cycle while m_ready is high.
`default_nettype none

module acesc_outq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_accept,
    input  wire acesc_pkg::acesc_grp_t grp_in,
    output logic                       in_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_byte_valid,
    output logic                       m_out_last,
    output logic                       m_stopped,
    output logic [15:0]                m_out_count
);
    import acesc_pkg::*;

    acesc_grp_t grp_reg, grp_next;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       at_end;
    logic       take;
    logic       done;
    logic       load;

    assign at_end   = (idx_reg == grp_reg.n - 2'd1);
    assign take     = busy_reg && m_ready;
    assign done     = take && at_end;
    assign load     = in_accept && (grp_in.n != 2'd0);
    assign in_ready = !busy_reg || done;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        grp_next  = grp_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
            grp_next  = grp_in;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        grp_reg <= grp_next;
    end

    assign m_valid      = busy_reg;
    assign m_out_byte   = grp_reg.bytes[idx_reg];
    assign m_byte_valid = !grp_reg.bare;
    assign m_out_last   = grp_reg.last && at_end;
    assign m_stopped    = grp_reg.stopped && at_end;
    assign m_out_count  = (grp_reg.last && at_end) ? grp_reg.count : 16'd0;

    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg < grp_reg.n))
        else $error("beat index beyond group size");

    a_bare_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && grp_reg.bare) |-> (grp_reg.n == 2'd1 && grp_reg.last))
        else $error("bare end marker not alone in its group");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !at_end) |=> (busy_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("beat index failed to advance");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !done) |-> !in_ready)
        else $error("input taken while group still pending");

endmodule

`default_nettype wire
